/* rtl/oversampled_uart_with_fifos_core_macros.svh */
// assertion macros for the oversampled uart core
// expects clk and arst_n in the scope of the module that uses them
`ifndef OVERSAMPLED_UART_WITH_FIFOS_CORE_MACROS_SVH
`define OVERSAMPLED_UART_WITH_FIFOS_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CORE_ASSERT(name, expr) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("core assertion failed");
`define CORE_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("core assertion failed");
`else
`define CORE_ASSERT(name, expr)
`define CORE_ASSERT_IMP(name, ante, cons)
`endif
`endif

/* rtl/ouart_pkg.sv */
// shared types and constants for the oversampled uart core
// no dependencies
package ouart_pkg;

	typedef enum logic [2:0] {
		CMD_TICK            = 3'd0,
		CMD_PUSH_TX         = 3'd1,
		CMD_POP_RX          = 3'd2,
		CMD_CLEAR_RX        = 3'd3,
		CMD_START_TX        = 3'd4,
		CMD_READ_CLEAR_TERM = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_DATA = 2'd1,
		PH_STOP = 2'd2
	} rx_phase_t;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TERMINATE_KEY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE     = 2'd1;

	localparam logic [7:0] TERM_KEY_RST = 8'd10;
	localparam logic [2:0] START_DELAY  = 3'd4;
	localparam logic [2:0] RX_BIT_TICKS = 3'd3;
	localparam logic [1:0] TX_BIT_TICKS = 2'd3;
	localparam logic [3:0] DATA_BITS    = 4'd8;
	localparam logic [3:0] FRAME_BITS   = 4'd10;
	localparam logic [9:0] FRAME_STOP   = 10'h200;

endpackage

/* rtl/oversampled_uart_with_fifos_core.sv */
// 8n1 uart at three ticks per bit with receive and transmit fifos
// depends on ouart_pkg and oversampled_uart_with_fifos_core_macros.svh
//
// usage:
//   input channel (in_valid/in_ready) carries one command item: cmd, rx_line,
//   tx_byte, peek_index. a tick command advances receiver and transmitter by
//   one oversampling tick; the others push, pop, clear, start or read-clear.
//   output channel (out_valid/out_ready) returns one status item per command:
//   line level, fifo levels, head and peek bytes, terminate flag, tx enable.
//   configuration channel (cfg_valid/cfg_ready) writes terminate_key (index 0)
//   and rx_enable (index 1); it is always ready.
//   result: registered, valid the cycle after the command is accepted.
//   throughput: one item per cycle; the single output register is refilled
//   in the same cycle it is taken, so in_ready only drops while a result waits
//   with out_ready low, and holds there until it is taken.
//   both fifo stores are plain memories with a registered read; no clearing
//   pass is needed since empty or out-of-range reads answer zero.
//   reset: fifos empty, tx line high, transmitter off, key 10, receiver on.
`include "oversampled_uart_with_fifos_core_macros.svh"

module oversampled_uart_with_fifos_core #(
	parameter int RX_DEPTH = 16,
	parameter int TX_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] cmd,
	input  logic       rx_line,
	input  logic [7:0] tx_byte,
	input  logic [3:0] peek_index,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       tx_line,
	output logic [7:0] head_byte,
	output logic [7:0] peek_byte,
	output logic [4:0] rx_level,
	output logic [4:0] tx_level,
	output logic       terminate_seen,
	output logic       tx_active
);
	import ouart_pkg::*;

	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int RX_CW = $clog2(RX_DEPTH + 1);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int TX_CW = $clog2(TX_DEPTH + 1);
	localparam int PKW   = (RX_CW > 4) ? RX_CW : 4;
	localparam int SW    = ((RX_AW > 4) ? RX_AW : 4) + 1;

	// configuration
	logic [7:0] term_key_q;
	logic       rx_en_q;

	// receiver
	rx_phase_t        rx_phase_q, rx_phase_d;
	logic [2:0]       rx_tmr_q, rx_tmr_d, rx_tmr_m1;
	logic [3:0]       rx_bits_q, rx_bits_d;
	logic [7:0]       rx_shift_q, rx_shift_d;
	logic             rx_strobe, rx_byte_done;
	logic [7:0]       rx_store [RX_DEPTH];
	logic [RX_AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d, peek_addr;
	logic [RX_CW-1:0] rx_count_q, rx_count_d;
	logic             rx_wr_en, rx_pop, rx_clr;
	logic [SW-1:0]    peek_sum;
	logic             term_q, term_d, term_tick;

	// transmitter
	logic [7:0]       tx_store [TX_DEPTH];
	logic [7:0]       tx_rd_q;
	logic [TX_AW-1:0] tx_head_d, tx_head_q, tx_tail_q, tx_tail_d;
	logic [TX_CW-1:0] tx_count_q, tx_count_d;
	logic             tx_on_q, tx_on_d;
	logic [1:0]       tx_tmr_q, tx_tmr_d, tx_tmr_m1;
	logic [3:0]       tx_bits_q, tx_bits_d, tx_bits_m1;
	logic [9:0]       tx_frame_q, tx_frame_d, tx_frame_cur;
	logic             tx_lvl_q, tx_lvl_d;
	logic             tx_wr_en, tx_shift_now;

	// result register
	logic       out_valid_q, seen_q, head_ok_q, peek_ok_q;
	logic [7:0] head_rd_q, peek_rd_q;

	logic accept, tick;
	cmd_t cmd_c;

	assign cmd_c     = cmd_t'(cmd);
	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign tick      = accept && (cmd_c == CMD_TICK);

	// receiver state machine: next phase
	assign rx_tmr_m1 = rx_tmr_q - 3'd1;
	assign rx_strobe = (rx_phase_q != PH_WAIT) && (rx_tmr_m1 == 3'd0);

	always_comb begin
		rx_phase_d = rx_phase_q;
		if (tick) begin
			if (!rx_en_q) begin
				rx_phase_d = PH_WAIT;
			end else begin
				case (rx_phase_q)
					PH_WAIT: begin
						if (!rx_line) rx_phase_d = PH_DATA;
					end
					PH_DATA: begin
						if (rx_strobe && (rx_bits_q == 4'd1)) rx_phase_d = PH_STOP;
					end
					PH_STOP: begin
						if (rx_strobe && rx_line) rx_phase_d = PH_WAIT;
					end
					default: begin
						rx_phase_d = PH_WAIT;
					end
				endcase
			end
		end
	end

	// receiver state machine: datapath actions
	always_comb begin
		rx_tmr_d     = rx_tmr_q;
		rx_bits_d    = rx_bits_q;
		rx_shift_d   = rx_shift_q;
		rx_byte_done = 1'b0;
		if (tick && rx_en_q) begin
			case (rx_phase_q)
				PH_WAIT: begin
					if (!rx_line) begin
						rx_tmr_d   = START_DELAY;
						rx_bits_d  = DATA_BITS;
						rx_shift_d = 8'd0;
					end
				end
				PH_DATA: begin
					rx_tmr_d = rx_strobe ? RX_BIT_TICKS : rx_tmr_m1;
					if (rx_strobe) begin
						rx_shift_d = {rx_line, rx_shift_q[7:1]};
						rx_bits_d  = rx_bits_q - 4'd1;
					end
				end
				default: begin
					// stop phase: resample every bit time until the line is high
					rx_tmr_d     = rx_strobe ? RX_BIT_TICKS : rx_tmr_m1;
					rx_byte_done = rx_strobe && rx_line;
				end
			endcase
		end
	end

	// rx fifo and terminate flag
	always_comb begin
		rx_wr_en  = rx_byte_done && (rx_count_q < RX_CW'(RX_DEPTH));
		rx_pop    = accept && (cmd_c == CMD_POP_RX) && (rx_count_q != '0);
		rx_clr    = accept && (cmd_c == CMD_CLEAR_RX);
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		rx_count_d = rx_count_q;
		if (rx_clr) begin
			rx_head_d  = rx_tail_q;
			rx_count_d = '0;
		end else if (rx_pop) begin
			rx_head_d  = (rx_head_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_head_q + 1'b1;
			rx_count_d = rx_count_q - 1'b1;
		end else if (rx_wr_en) begin
			rx_count_d = rx_count_q + 1'b1;
		end
		if (rx_wr_en) begin
			rx_tail_d = (rx_tail_q == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_tail_q + 1'b1;
		end
		term_tick = term_q || (rx_byte_done && (rx_shift_q == term_key_q));
		term_d    = (accept && (cmd_c == CMD_READ_CLEAR_TERM)) ? 1'b0 : term_tick;
		// head plus offset wraps at most once when the offset is within count
		peek_sum = SW'(rx_head_q) + SW'(peek_index);
		if (peek_sum >= SW'(RX_DEPTH)) peek_sum = peek_sum - SW'(RX_DEPTH);
		peek_addr = peek_sum[RX_AW-1:0];
	end

	// transmitter
	assign tx_tmr_m1  = tx_tmr_q - 2'd1;
	assign tx_bits_m1 = tx_bits_q - 4'd1;

	always_comb begin
		tx_wr_en     = accept && (cmd_c == CMD_PUSH_TX) && (tx_count_q < TX_CW'(TX_DEPTH));
		tx_shift_now = tick && (tx_tmr_m1 == 2'd0) && (tx_count_q != '0) && tx_on_q;
		tx_tmr_d     = tx_tmr_q;
		tx_bits_d    = tx_bits_q;
		tx_frame_d   = tx_frame_q;
		tx_lvl_d     = tx_lvl_q;
		tx_head_d    = tx_head_q;
		tx_tail_d    = tx_tail_q;
		tx_count_d   = tx_count_q;
		tx_on_d      = tx_on_q;
		tx_frame_cur = (tx_bits_q == FRAME_BITS) ? ({1'b0, tx_rd_q, 1'b0} | FRAME_STOP)
			: tx_frame_q;
		if (tick) begin
			tx_tmr_d = (tx_tmr_m1 == 2'd0) ? TX_BIT_TICKS : tx_tmr_m1;
		end
		if (tx_shift_now) begin
			tx_lvl_d   = tx_frame_cur[0];
			tx_frame_d = {1'b0, tx_frame_cur[9:1]};
			tx_bits_d  = tx_bits_m1;
			if (tx_bits_m1 == 4'd0) begin
				// last bit of the frame: retire the byte
				tx_bits_d  = FRAME_BITS;
				tx_head_d  = (tx_head_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_head_q + 1'b1;
				tx_count_d = tx_count_q - 1'b1;
				if (tx_count_q == TX_CW'(1)) tx_on_d = 1'b0;
				tx_lvl_d   = 1'b1;
			end
		end
		if (tx_wr_en) begin
			tx_tail_d  = (tx_tail_q == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_tail_q + 1'b1;
			tx_count_d = tx_count_q + 1'b1;
		end
		if (accept && (cmd_c == CMD_START_TX) && !tx_on_q) begin
			tx_bits_d = FRAME_BITS;
			tx_on_d   = 1'b1;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_key_q <= TERM_KEY_RST;
			rx_en_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_TERMINATE_KEY: term_key_q <= cfg_data;
				CFG_RX_ENABLE:     rx_en_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q  <= PH_WAIT;
			rx_tmr_q    <= 3'd0;
			rx_bits_q   <= 4'd0;
			rx_shift_q  <= 8'd0;
			rx_head_q   <= '0;
			rx_tail_q   <= '0;
			rx_count_q  <= '0;
			term_q      <= 1'b0;
			tx_head_q   <= '0;
			tx_tail_q   <= '0;
			tx_count_q  <= '0;
			tx_on_q     <= 1'b0;
			tx_tmr_q    <= TX_BIT_TICKS;
			tx_bits_q   <= FRAME_BITS;
			tx_frame_q  <= 10'd0;
			tx_lvl_q    <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			rx_phase_q  <= rx_phase_d;
			rx_tmr_q    <= rx_tmr_d;
			rx_bits_q   <= rx_bits_d;
			rx_shift_q  <= rx_shift_d;
			rx_head_q   <= rx_head_d;
			rx_tail_q   <= rx_tail_d;
			rx_count_q  <= rx_count_d;
			term_q      <= term_d;
			tx_head_q   <= tx_head_d;
			tx_tail_q   <= tx_tail_d;
			tx_count_q  <= tx_count_d;
			tx_on_q     <= tx_on_d;
			tx_tmr_q    <= tx_tmr_d;
			tx_bits_q   <= tx_bits_d;
			tx_frame_q  <= tx_frame_d;
			tx_lvl_q    <= tx_lvl_d;
			if (in_ready) out_valid_q <= in_valid;
		end
	end

	// rx store: one write port, head and peek reads registered with the item
	always_ff @(posedge clk) begin
		if (rx_wr_en) rx_store[rx_tail_q] <= rx_shift_q;
		if (accept) begin
			head_rd_q <= rx_store[rx_head_q];
			peek_rd_q <= rx_store[peek_addr];
			head_ok_q <= (rx_count_q != '0);
			peek_ok_q <= (PKW'(peek_index) < PKW'(rx_count_q));
			seen_q    <= term_tick;
		end
	end

	// tx store: prefetch the next head entry, bypassing a push into it
	always_ff @(posedge clk) begin
		if (tx_wr_en) tx_store[tx_tail_q] <= tx_byte;
		if (tx_wr_en && (tx_tail_q == tx_head_d)) begin
			tx_rd_q <= tx_byte;
		end else begin
			tx_rd_q <= tx_store[tx_head_d];
		end
	end

	// state only moves on an accepted item, so it mirrors the held result
	assign out_valid      = out_valid_q;
	assign tx_line        = tx_lvl_q;
	assign head_byte      = head_ok_q ? head_rd_q : 8'd0;
	assign peek_byte      = peek_ok_q ? peek_rd_q : 8'd0;
	assign rx_level       = 5'(rx_count_q);
	assign tx_level       = 5'(tx_count_q);
	assign terminate_seen = seen_q;
	assign tx_active      = tx_on_q;

	`CORE_ASSERT(a_rx_count_bound, rx_count_q <= RX_CW'(RX_DEPTH))
	`CORE_ASSERT(a_tx_count_bound, tx_count_q <= TX_CW'(TX_DEPTH))
	`CORE_ASSERT_IMP(a_tx_off_when_empty, $fell(tx_on_q), tx_count_q == '0)
	`CORE_ASSERT_IMP(a_rx_data_bits, rx_phase_q == PH_DATA, rx_bits_q != 4'd0)
	`CORE_ASSERT(a_tx_bits_range, (tx_bits_q != 4'd0) && (tx_bits_q <= FRAME_BITS))

endmodule
